// ----- sv/wide_multiply_add_round_macros.svh -----
// assertion helpers, clock and reset taken from the enclosing module
`ifndef WIDE_MULTIPLY_ADD_ROUND_MACROS_SVH
`define WIDE_MULTIPLY_ADD_ROUND_MACROS_SVH

// same-cycle implication
`define WMAR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wmar assertion failed");

// next-cycle implication
`define WMAR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wmar assertion failed");

`endif

// ----- sv/wmar_pkg.sv -----
`timescale 1ns / 1ps
package wmar_pkg;

    localparam int SIG_MAX = 128;
    localparam int ACC_MAX = 256;
    localparam int X_W     = 388;
    localparam int SH_W    = 9;
    localparam int SCALE_W = 17;
    localparam int EXP_W   = 18;
    localparam int KEEP_W  = 7;
    localparam int MODE_W  = 3;
    localparam int DSH_W   = 10;

    localparam logic CMD_MUL = 1'b0;
    localparam logic CMD_ADD = 1'b1;

    localparam logic [MODE_W-1:0] RM_NEAREST = 3'd0;
    localparam logic [MODE_W-1:0] RM_CHOP    = 3'd1;
    localparam logic [MODE_W-1:0] RM_UP      = 3'd2;
    localparam logic [MODE_W-1:0] RM_DOWN    = 3'd3;
    localparam logic [MODE_W-1:0] RM_AWAY    = 3'd4;
    localparam logic [MODE_W-1:0] RM_ODD     = 3'd5;

    typedef struct packed {
        logic                       cmd;
        logic                       a_sign;
        logic [SIG_MAX-1:0]         a_sig;
        logic                       a_use;
        logic [SH_W-1:0]            a_sh;
        logic                       b_sign;
        logic [SIG_MAX-1:0]         b_sig;
        logic                       b_use;
        logic [SH_W-1:0]            b_sh;
        logic signed [SCALE_W-1:0]  scale;
        logic [KEEP_W-1:0]          keep;
        logic [MODE_W-1:0]          mode;
        logic                       range;
    } t_issue;

    typedef struct packed {
        logic                       cmd;
        logic                       a_sign;
        logic                       b_sign;
        logic                       neg;
        logic signed [SCALE_W-1:0]  scale;
        logic [KEEP_W-1:0]          keep;
        logic [MODE_W-1:0]          mode;
        logic                       range;
    } t_meta;

    typedef struct packed {
        logic                       sign;
        logic [SIG_MAX-1:0]         sig;
        logic signed [EXP_W-1:0]    exp;
        logic signed [1:0]          dir;
        logic                       range;
    } t_result;

    function automatic logic [4:0] msb_pos32(input logic [31:0] v);
        logic [4:0] pos;
        pos = '0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                pos = 5'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ----- sv/wmar_queue.sv -----
`timescale 1ns / 1ps
module wmar_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd, n_wr, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr  = wr_en ? ((r_wr == LastPtr) ? '0 : r_wr + 1'b1) : r_wr;
        n_rd  = rd_en ? ((r_rd == LastPtr) ? '0 : r_rd + 1'b1) : r_rd;
        n_cnt = r_cnt + CW'(wr_en) - CW'(rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- sv/wmar_front.sv -----
`timescale 1ns / 1ps
module wmar_front #(
    parameter int SIG_WIDTH = 128,
    parameter int ACC_WIDTH = 256
) (
    input  logic                 i_cmd,
    input  logic                 i_a_sign,
    input  logic [63:0]          i_a_sig_hi,
    input  logic [63:0]          i_a_sig_lo,
    input  logic signed [15:0]   i_a_exp,
    input  logic                 i_b_sign,
    input  logic [63:0]          i_b_sig_hi,
    input  logic [63:0]          i_b_sig_lo,
    input  logic signed [15:0]   i_b_exp,
    input  logic [6:0]           i_keep_bits,
    input  logic [2:0]           i_round_mode,
    output wmar_pkg::t_issue     o_item
);
    import wmar_pkg::*;

    localparam logic [SIG_MAX-1:0] SigMask  = {SIG_MAX{1'b1}} >> (SIG_MAX - SIG_WIDTH);
    localparam logic [KEEP_W-1:0]  KeepMax  = KEEP_W'(SIG_WIDTH - 1);
    localparam logic [SCALE_W-1:0] AccLimit = SCALE_W'(ACC_WIDTH);

    logic [SIG_MAX-1:0]        sa, sb;
    logic signed [SCALE_W-1:0] ea, eb, scale;
    logic [SCALE_W-1:0]        da, db;
    logic                      a_nz, b_nz, a_far, b_far;

    always_comb begin
        sa    = {i_a_sig_hi, i_a_sig_lo} & SigMask;
        sb    = {i_b_sig_hi, i_b_sig_lo} & SigMask;
        a_nz  = |sa;
        b_nz  = |sb;
        ea    = SCALE_W'(i_a_exp);
        eb    = SCALE_W'(i_b_exp);
        if (i_cmd == CMD_MUL) begin
            scale = ea + eb;
        end else begin
            scale = (ea < eb) ? ea : eb;
        end
        da    = ea - scale;
        db    = eb - scale;
        a_far = da > AccLimit;
        b_far = db > AccLimit;

        o_item.cmd    = i_cmd;
        o_item.a_sign = i_a_sign;
        o_item.a_sig  = sa;
        o_item.a_use  = a_nz && !a_far;
        o_item.a_sh   = da[SH_W-1:0];
        o_item.b_sign = i_b_sign;
        o_item.b_sig  = sb;
        o_item.b_use  = b_nz && !b_far;
        o_item.b_sh   = db[SH_W-1:0];
        o_item.scale  = scale;
        o_item.mode   = i_round_mode;
        o_item.range  = (i_cmd == CMD_ADD) && ((a_nz && a_far) || (b_nz && b_far));
        if (i_keep_bits == '0) begin
            o_item.keep = KEEP_W'(1);
        end else if (i_keep_bits > KeepMax) begin
            o_item.keep = KeepMax;
        end else begin
            o_item.keep = i_keep_bits;
        end
    end

endmodule

// ----- sv/wmar_back.sv -----
`timescale 1ns / 1ps
module wmar_back #(
    parameter int ACC_WIDTH = 256,
    parameter int OQ_DEPTH  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wmar_pkg::t_issue  i_item,
    input  logic              i_item_valid,
    output logic              o_take,
    output wmar_pkg::t_result o_res,
    output logic              o_res_valid,
    input  logic              i_res_taken
);
    import wmar_pkg::*;
    `include "wide_multiply_add_round_macros.svh"

    localparam int NST = 9;
    localparam int UW  = $clog2(OQ_DEPTH + 1);

    logic [UW-1:0]     r_used, n_used;
    logic [NST-1:0]    r_v;
    t_meta             r_m [NST];
    t_meta             m_in, m6;

    logic [63:0]       r_pp [4][4];
    logic [X_W-1:0]    r_xa, r_xb;
    logic [159:0]      r_row [4];
    logic [X_W-1:0]    r_sum2, r_sum3, r_sum4, r_exact;
    logic [191:0]      r_s01, r_s23;
    logic [255:0]      r_prod;
    logic [255:0]      r_mag6, r_mag7, r_mag8;
    logic [7:0]        r_cnz;
    logic [4:0]        r_cpos [8];
    logic signed [DSH_W-1:0] r_sh8, r_sh9;
    logic              r_nz8, r_nz9;
    logic [SIG_MAX-1:0] r_t;
    logic              r_guard, r_below;

    // combinational stage values
    logic [X_W-1:0]    xa_n, xb_n, prod_x, exact_n;
    logic [ACC_MAX-1:0] w_n, mag_n;
    logic signed [ACC_WIDTH-1:0] wrap_n;
    logic [X_W-ACC_WIDTH:0] upper_n;
    logic              ovf_n;
    logic [7:0]        msb_n;
    logic              nz_n;
    logic signed [DSH_W-1:0] sh_n;
    logic [383:0]      p_n, sft_n;
    logic [SH_W-1:0]   amt_n, gp_n;
    logic              disc, inc, add_one, full;
    logic [SIG_MAX:0]  sum_r;
    logic [SIG_MAX-1:0] t_fin;
    logic signed [DSH_W-1:0] sh_fin;
    logic signed [1:0] rh;

    assign o_take = i_item_valid && (r_used < UW'(OQ_DEPTH));

    always_comb begin
        n_used = r_used + UW'(o_take) - UW'(i_res_taken);
    end

    always_comb begin
        m_in.cmd    = i_item.cmd;
        m_in.a_sign = i_item.a_sign;
        m_in.b_sign = i_item.b_sign;
        m_in.neg    = 1'b0;
        m_in.scale  = i_item.scale;
        m_in.keep   = i_item.keep;
        m_in.mode   = i_item.mode;
        m_in.range  = i_item.range;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_v    <= '0;
        end else begin
            r_used <= n_used;
            r_v    <= {r_v[NST-2:0], o_take};
        end
    end

    // stage 1: partial products and alignment
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                r_pp[i][j] <= {32'b0, i_item.a_sig[32*i +: 32]}
                            * {32'b0, i_item.b_sig[32*j +: 32]};
            end
        end
        r_xa   <= i_item.a_use ? (X_W'(i_item.a_sig) << i_item.a_sh) : '0;
        r_xb   <= i_item.b_use ? (X_W'(i_item.b_sig) << i_item.b_sh) : '0;
        r_m[0] <= m_in;
    end

    // stage 2: product rows, signed sum
    always_comb begin
        xa_n = r_m[0].a_sign ? ~r_xa : r_xa;
        xb_n = r_m[0].b_sign ? ~r_xb : r_xb;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_row[i] <= {32'b0, r_pp[i][2], r_pp[i][0]} + {r_pp[i][3], r_pp[i][1], 32'b0};
        end
        r_sum2 <= xa_n + xb_n + X_W'(r_m[0].a_sign) + X_W'(r_m[0].b_sign);
        r_m[1] <= r_m[0];
    end

    // stage 3 and 4: row merge
    always_ff @(posedge i_clk) begin
        r_s01  <= {32'b0, r_row[0]} + {r_row[1], 32'b0};
        r_s23  <= {32'b0, r_row[2]} + {r_row[3], 32'b0};
        r_sum3 <= r_sum2;
        r_m[2] <= r_m[1];
        r_prod <= {r_s23, 64'b0} + {64'b0, r_s01};
        r_sum4 <= r_sum3;
        r_m[3] <= r_m[2];
    end

    // stage 5: exact value
    always_comb begin
        prod_x = X_W'(r_prod);
        if (r_m[3].cmd == CMD_MUL) begin
            exact_n = (r_m[3].a_sign ^ r_m[3].b_sign) ? (~prod_x + 1'b1) : prod_x;
        end else begin
            exact_n = r_sum4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_exact <= exact_n;
        r_m[4]  <= r_m[3];
    end

    // stage 6: wrap, overflow, magnitude
    always_comb begin
        upper_n  = r_exact[X_W-1:ACC_WIDTH-1];
        ovf_n    = !((&upper_n) || (~|upper_n));
        wrap_n   = r_exact[ACC_WIDTH-1:0];
        w_n      = ACC_MAX'(wrap_n);
        mag_n    = w_n[ACC_MAX-1] ? (~w_n + 1'b1) : w_n;
        m6       = r_m[4];
        m6.neg   = w_n[ACC_MAX-1];
        m6.range = r_m[4].range || ovf_n;
    end

    always_ff @(posedge i_clk) begin
        r_mag6 <= mag_n;
        r_m[5] <= m6;
    end

    // stage 7: leading one per word
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 8; c++) begin
            r_cnz[c]  <= |r_mag6[32*c +: 32];
            r_cpos[c] <= msb_pos32(r_mag6[32*c +: 32]);
        end
        r_mag7 <= r_mag6;
        r_m[6] <= r_m[5];
    end

    // stage 8: leading one overall, shift amount
    always_comb begin
        msb_n = '0;
        for (int c = 0; c < 8; c++) begin
            if (r_cnz[c]) begin
                msb_n = {3'(c), r_cpos[c]};
            end
        end
        nz_n = |r_cnz;
        sh_n = $signed({2'b0, msb_n}) - $signed({3'b0, r_m[6].keep}) + DSH_W'(1);
    end

    always_ff @(posedge i_clk) begin
        r_sh8  <= sh_n;
        r_nz8  <= nz_n;
        r_mag8 <= r_mag7;
        r_m[7] <= r_m[6];
    end

    // stage 9: extract kept bits, guard and sticky
    always_comb begin
        p_n   = {r_mag8, 128'b0};
        amt_n = SH_W'(r_sh8 + DSH_W'(128));
        gp_n  = SH_W'(r_sh8 + DSH_W'(127));
        sft_n = p_n >> amt_n;
    end

    always_ff @(posedge i_clk) begin
        r_t     <= sft_n[SIG_MAX-1:0];
        r_guard <= p_n[gp_n];
        r_below <= |(p_n & ~({384{1'b1}} << gp_n));
        r_sh9   <= r_sh8;
        r_nz9   <= r_nz8;
        r_m[8]  <= r_m[7];
    end

    // rounding, into the result queue
    always_comb begin
        disc = r_guard || r_below;
        unique case (r_m[8].mode)
            RM_NEAREST: inc = r_guard && (r_below || r_t[0]);
            RM_CHOP:    inc = 1'b0;
            RM_UP:      inc = !r_m[8].neg && disc;
            RM_DOWN:    inc = r_m[8].neg && disc;
            RM_AWAY:    inc = disc;
            RM_ODD:     inc = disc && !r_t[0];
            default:    inc = 1'b0;
        endcase
        add_one = inc && (r_m[8].mode != RM_ODD);
        sum_r   = {1'b0, r_t} + (SIG_MAX + 1)'(add_one);
        full    = add_one && (sum_r == ((SIG_MAX + 1)'(1) << r_m[8].keep));
        sh_fin  = r_sh9;
        if (r_m[8].mode == RM_ODD) begin
            t_fin = {r_t[SIG_MAX-1:1], r_t[0] | disc};
        end else if (full) begin
            t_fin  = sum_r[SIG_MAX:1];
            sh_fin = r_sh9 + DSH_W'(1);
        end else begin
            t_fin = sum_r[SIG_MAX-1:0];
        end
        rh = disc ? (inc ? 2'sd1 : -2'sd1) : 2'sd0;
        if (r_m[8].neg) begin
            rh = -rh;
        end
        o_res.range = r_m[8].range;
        if (r_nz9) begin
            o_res.sign = r_m[8].neg;
            o_res.sig  = t_fin;
            o_res.exp  = EXP_W'(r_m[8].scale) + EXP_W'(sh_fin);
            o_res.dir  = rh;
        end else begin
            o_res.sign = 1'b0;
            o_res.sig  = '0;
            o_res.exp  = '0;
            o_res.dir  = 2'sd0;
        end
    end

    assign o_res_valid = r_v[NST-1];

    `WMAR_ASSERT_IMP(a_used_bound, 1'b1, r_used <= UW'(OQ_DEPTH))
    `WMAR_ASSERT_NXT(a_issue_enters, o_take, r_v[0])
    `WMAR_ASSERT_IMP(a_drain_credited, r_v[NST-1], r_used != '0)

endmodule

// ----- sv/wide_multiply_add_round.sv -----
// throughput: one item per cycle through the 9-stage multiply/align/round pipeline
// issue into the pipeline is limited by free result queue slots (OQ_DEPTH)
// synchronous active-low reset empties both queues and the pipeline
`timescale 1ns / 1ps
module wide_multiply_add_round #(
    parameter int SIG_WIDTH = 128,
    parameter int ACC_WIDTH = 256,
    parameter int IQ_DEPTH  = 4,
    parameter int OQ_DEPTH  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_cmd,
    input  logic               i_a_sign,
    input  logic [63:0]        i_a_sig_hi,
    input  logic [63:0]        i_a_sig_lo,
    input  logic signed [15:0] i_a_exp,
    input  logic               i_b_sign,
    input  logic [63:0]        i_b_sig_hi,
    input  logic [63:0]        i_b_sig_lo,
    input  logic signed [15:0] i_b_exp,
    input  logic [6:0]         i_keep_bits,
    input  logic [2:0]         i_round_mode,
    output logic               empty,
    input  logic               pop,
    output logic               o_res_sign,
    output logic [63:0]        o_res_sig_hi,
    output logic [63:0]        o_res_sig_lo,
    output logic signed [17:0] o_res_exp,
    output logic signed [1:0]  o_round_dir,
    output logic               o_range_error
);
    import wmar_pkg::*;

    localparam int IW = $bits(t_issue);
    localparam int RW = $bits(t_result);

    t_issue          fr_item, bk_item;
    logic [IW-1:0]   iq_out;
    logic            iq_empty, bk_take;
    t_result         bk_res, rq_res;
    logic [RW-1:0]   rq_out;
    logic            bk_res_valid, rq_full, res_xfer;

    wmar_front #(
        .SIG_WIDTH (SIG_WIDTH),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_front (
        .i_cmd        (i_cmd),
        .i_a_sign     (i_a_sign),
        .i_a_sig_hi   (i_a_sig_hi),
        .i_a_sig_lo   (i_a_sig_lo),
        .i_a_exp      (i_a_exp),
        .i_b_sign     (i_b_sign),
        .i_b_sig_hi   (i_b_sig_hi),
        .i_b_sig_lo   (i_b_sig_lo),
        .i_b_exp      (i_b_exp),
        .i_keep_bits  (i_keep_bits),
        .i_round_mode (i_round_mode),
        .o_item       (fr_item)
    );

    wmar_queue #(
        .WIDTH (IW),
        .DEPTH (IQ_DEPTH)
    ) u_issue_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (fr_item),
        .i_pop   (bk_take),
        .o_full  (full),
        .o_empty (iq_empty),
        .o_data  (iq_out)
    );

    assign bk_item = t_issue'(iq_out);

    wmar_back #(
        .ACC_WIDTH (ACC_WIDTH),
        .OQ_DEPTH  (OQ_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (bk_item),
        .i_item_valid (!iq_empty),
        .o_take       (bk_take),
        .o_res        (bk_res),
        .o_res_valid  (bk_res_valid),
        .i_res_taken  (res_xfer)
    );

    wmar_queue #(
        .WIDTH (RW),
        .DEPTH (OQ_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (bk_res_valid),
        .i_data  (bk_res),
        .i_pop   (pop),
        .o_full  (rq_full),
        .o_empty (empty),
        .o_data  (rq_out)
    );

    // result transfer frees one credit
    assign res_xfer      = pop && !empty;
    assign rq_res        = t_result'(rq_out);
    assign o_res_sign    = rq_res.sign;
    assign o_res_sig_hi  = rq_res.sig[127:64];
    assign o_res_sig_lo  = rq_res.sig[63:0];
    assign o_res_exp     = rq_res.exp;
    assign o_round_dir   = rq_res.dir;
    assign o_range_error = rq_res.range;

    logic unused_full;
    assign unused_full = rq_full;

endmodule
